FILE: sv/alp_pkg.sv
`timescale 1ns / 1ps
// Address lease pool: shared types, codes and field widths.
package alp_pkg;

	localparam int MAC_W      = 48;
	localparam int IP_W       = 32;
	localparam int STATUS_W   = 3;
	localparam int SIZE_W     = 9;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 40;

	localparam logic [CFG_ADDR_W-1:0] REG_POOL_BASE_IP = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_POOL_SIZE    = 1'd1;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_EXISTING   = 3'd0,
		ST_NEW        = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_EXHAUSTED  = 3'd3,
		ST_RELEASED   = 3'd4,
		ST_UNKNOWN    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FIND,
		S_POOL,
		S_SHIFT,
		S_RESP
	} state_t;

endpackage

FILE: sv/alp_bitmap.sv
`timescale 1ns / 1ps
// Address lease pool: in-use bitmap memory with clearing pass after reset.
module alp_bitmap #(
	parameter int POOL_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          init_done,
	input  logic                          rd_en,
	input  logic [$clog2(POOL_DEPTH)-1:0] rd_addr,
	output logic                          rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(POOL_DEPTH)-1:0] wr_addr,
	input  logic                          wr_data
);

	localparam int OW = $clog2(POOL_DEPTH);
	localparam logic [OW-1:0] LAST = OW'(POOL_DEPTH - 1);

	logic          mem [POOL_DEPTH];
	logic [OW-1:0] clr_q;
	logic          busy_q;
	logic          rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == LAST) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign init_done = !busy_q;
	assign rd_data   = rd_q;

endmodule

FILE: sv/address_lease_pool_core.sv
`timescale 1ns / 1ps
// Path to m_tvalid: client scan, then a pool scan for a new request or a table move
// on a release hit (other outcomes go straight on), then the result is registered.
// Throughput: one word at a time, the next taken the cycle after the result is registered.
// Reset: registers to defaults, no clients; the bitmap is cleared after reset,
// during which no input word is taken.
module address_lease_pool_core #(
	parameter int MAX_CLIENTS = 64,
	parameter int POOL_DEPTH  = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [alp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [alp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [alp_pkg::S_TDATA_W-1:0]   s_tdata,  // client_mac[47:0]
	input  logic                            s_tuser,  // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [alp_pkg::M_TDATA_W-1:0]   m_tdata   // status[2:0], lease_ip[34:3]
);

	localparam int CIW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW  = $clog2(MAX_CLIENTS + 1);
	localparam int OW  = $clog2(POOL_DEPTH);
	localparam int PW  = $clog2(POOL_DEPTH + 1);
	localparam int LW  = (PW > alp_pkg::SIZE_W) ? PW : alp_pkg::SIZE_W;
	localparam int EW  = alp_pkg::MAC_W + OW;

	alp_pkg::state_t  state_q, state_d;

	logic [alp_pkg::IP_W-1:0]   base_q;
	logic [alp_pkg::SIZE_W-1:0] size_q;
	logic [CW-1:0]              cnt_q;
	logic                       cmd_q;
	logic [alp_pkg::MAC_W-1:0]  mac_q;
	logic [CW-1:0]              scan_q;
	logic [PW-1:0]              pscan_q;
	logic                       vld_s1, pvld_s1;
	logic [CIW-1:0]             idx_s1;
	logic [OW-1:0]              pidx_s1;
	alp_pkg::status_t           res_status_q, out_status_q;
	logic [alp_pkg::IP_W-1:0]   res_ip_q, out_ip_q;
	logic                       out_vld_q;

	logic                      mem_we;
	logic [CIW-1:0]            mem_waddr;
	logic [EW-1:0]             mem_wdata;
	logic                      mem_re;
	logic [EW-1:0]             mem [MAX_CLIENTS];
	logic [EW-1:0]             ent_q;
	logic [alp_pkg::MAC_W-1:0] ent_mac;
	logic [OW-1:0]             ent_off;

	logic          bm_init_done, bm_re, bm_rdata, bm_we, bm_wdata;
	logic [OW-1:0] bm_waddr;

	logic          accept, hit, find_end, shift_end, free_hit, pool_end, tab_full, out_load;
	logic          tab_issue, bm_issue;
	logic [LW-1:0] size_ext, lim;
	logic [CW-1:0] shift_tgt;

	assign ent_mac   = ent_q[EW-1:OW];
	assign ent_off   = ent_q[OW-1:0];
	assign size_ext  = LW'(size_q);
	assign lim       = (size_ext > LW'(POOL_DEPTH)) ? LW'(POOL_DEPTH) : size_ext;
	assign tab_full  = cnt_q >= CW'(MAX_CLIENTS);
	assign shift_tgt = scan_q - CW'(1);

	assign accept    = s_tvalid && s_tready;
	assign hit       = (state_q == alp_pkg::S_FIND) && vld_s1 && (ent_mac == mac_q);
	assign find_end  = (state_q == alp_pkg::S_FIND) && !vld_s1 && (scan_q >= cnt_q);
	assign shift_end = (state_q == alp_pkg::S_SHIFT) && !vld_s1 && (scan_q >= cnt_q);
	assign free_hit  = (state_q == alp_pkg::S_POOL) && pvld_s1 && !bm_rdata;
	assign pool_end  = (state_q == alp_pkg::S_POOL) && !pvld_s1 && (LW'(pscan_q) >= lim);
	assign out_load  = (state_q == alp_pkg::S_RESP) && (!out_vld_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			alp_pkg::S_INIT: begin
				if (bm_init_done) state_d = alp_pkg::S_IDLE;
			end
			alp_pkg::S_IDLE: begin
				if (s_tvalid) state_d = alp_pkg::S_FIND;
			end
			alp_pkg::S_FIND: begin
				if (hit) begin
					state_d = (cmd_q == alp_pkg::CMD_RELEASE) ? alp_pkg::S_SHIFT : alp_pkg::S_RESP;
				end else if (find_end) begin
					state_d = (cmd_q == alp_pkg::CMD_REQUEST && !tab_full) ?
						alp_pkg::S_POOL : alp_pkg::S_RESP;
				end
			end
			alp_pkg::S_POOL: begin
				if (free_hit || pool_end) state_d = alp_pkg::S_RESP;
			end
			alp_pkg::S_SHIFT: begin
				if (shift_end) state_d = alp_pkg::S_RESP;
			end
			alp_pkg::S_RESP: begin
				if (out_load) state_d = alp_pkg::S_IDLE;
			end
			default: state_d = alp_pkg::S_INIT;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		tab_issue = 1'b0;
		bm_issue  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = ent_q;
		bm_we     = 1'b0;
		bm_waddr  = ent_off;
		bm_wdata  = 1'b0;
		case (state_q)
			alp_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			alp_pkg::S_FIND: begin
				tab_issue = !hit && (scan_q < cnt_q);
				if (hit && cmd_q == alp_pkg::CMD_RELEASE) begin
					bm_we = 1'b1;
				end
			end
			alp_pkg::S_SHIFT: begin
				tab_issue = scan_q < cnt_q;
				mem_we    = vld_s1;
			end
			alp_pkg::S_POOL: begin
				bm_issue = !free_hit && (LW'(pscan_q) < lim);
				if (free_hit) begin
					bm_we     = 1'b1;
					bm_waddr  = pidx_s1;
					bm_wdata  = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = cnt_q[CIW-1:0];
					mem_wdata = {mac_q, pidx_s1};
				end
			end
			default: begin
			end
		endcase
	end
	assign mem_re = tab_issue;
	assign bm_re  = bm_issue;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) ent_q <= mem[scan_q[CIW-1:0]];
	end

	alp_bitmap #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_bitmap (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_done (bm_init_done),
		.rd_en     (bm_re),
		.rd_addr   (pscan_q[OW-1:0]),
		.rd_data   (bm_rdata),
		.wr_en     (bm_we),
		.wr_addr   (bm_waddr),
		.wr_data   (bm_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= alp_pkg::S_INIT;
			base_q    <= '0;
			size_q    <= alp_pkg::SIZE_W'(256);
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			pvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= tab_issue;
			pvld_s1 <= bm_issue;
			if (cfg_we && cfg_addr == alp_pkg::REG_POOL_BASE_IP) begin
				base_q <= cfg_wdata;
			end
			if (cfg_we && cfg_addr == alp_pkg::REG_POOL_SIZE) begin
				size_q <= cfg_wdata[alp_pkg::SIZE_W-1:0];
			end
			if (free_hit) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (shift_end) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			mac_q   <= s_tdata[alp_pkg::MAC_W-1:0];
			scan_q  <= '0;
			pscan_q <= '0;
		end
		if (tab_issue) begin
			scan_q <= scan_q + CW'(1);
			idx_s1 <= (state_q == alp_pkg::S_SHIFT) ? shift_tgt[CIW-1:0] : scan_q[CIW-1:0];
		end
		if (bm_issue) begin
			pscan_q <= pscan_q + PW'(1);
			pidx_s1 <= pscan_q[OW-1:0];
		end
		if (hit) begin
			if (cmd_q == alp_pkg::CMD_RELEASE) begin
				scan_q       <= CW'(idx_s1) + CW'(1);
				res_status_q <= alp_pkg::ST_RELEASED;
				res_ip_q     <= '0;
			end else begin
				res_status_q <= alp_pkg::ST_EXISTING;
				res_ip_q     <= base_q + alp_pkg::IP_W'(ent_off);
			end
		end else if (find_end) begin
			res_ip_q <= '0;
			if (cmd_q == alp_pkg::CMD_RELEASE) begin
				res_status_q <= alp_pkg::ST_UNKNOWN;
			end else if (tab_full) begin
				res_status_q <= alp_pkg::ST_TABLE_FULL;
			end else begin
				res_status_q <= alp_pkg::ST_EXHAUSTED;
			end
		end
		if (free_hit) begin
			res_status_q <= alp_pkg::ST_NEW;
			res_ip_q     <= base_q + alp_pkg::IP_W'(pidx_s1);
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_ip_q     <= res_ip_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(alp_pkg::M_TDATA_W - alp_pkg::IP_W - alp_pkg::STATUS_W){1'b0}},
		out_ip_q, out_status_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CLIENTS))
		else $error("client count beyond table depth");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> bm_init_done)
		else $error("word taken during bitmap clearing");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == alp_pkg::S_RESP))
		else $error("result raised outside response state");

	a_tab_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == alp_pkg::S_SHIFT || state_q == alp_pkg::S_POOL))
		else $error("client table written outside move or allocation");

endmodule

FILE: bench/address_lease_pool_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for address_lease_pool_core: directed table, random phases, own lease predictor.
module address_lease_pool_core_tb;
	import alp_pkg::*;

	localparam int CLIENT_SLOTS    = 64;
	localparam int POOL_SLOTS      = 256;
	localparam int SCRIPT_ROWS     = 27;
	localparam int PHASES          = 8;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 400;
	localparam int HOLD_CYCLES     = 700;
	localparam int HOLD_AT_WORD    = 200;
	localparam int WATCHDOG_CYCLES = 5000;

	typedef struct packed {
		status_t     status;
		logic [31:0] ip;
	} lease_answer_t;

	typedef enum bit {WORD_ROW, REG_ROW} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_ADDR_W-1:0] idx;
		logic [31:0]           value;
		logic                  cmd;
		logic [MAC_W-1:0]      mac;
		bit                    typed;
		status_t               status;
		logic [31:0]           ip;
	} lease_row_t;

	typedef struct {
		logic [31:0] base;
		bit          base_rand;
		logic [8:0]  size;
		bit          size_rand;
		int          items;
		int          rel_pct;
		int          known_pct;
	} phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // client_mac[47:0]
	logic                  s_tuser;   // cmd
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // status[2:0], lease_ip[34:3]

	// predictor state
	logic [31:0]           base_ip  = 32'h0;
	logic [8:0]            size_reg = 9'd256;
	logic [MAC_W-1:0]      held_mac [CLIENT_SLOTS];
	logic [7:0]            held_off [CLIENT_SLOTS];
	int                    held_count = 0;
	logic [POOL_SLOTS-1:0] slot_busy  = '0;

	lease_answer_t lease_answers_q [$];
	lease_answer_t due;
	int            n_fail = 0;
	int            words_out = 0;
	int            stall_left = 0;
	int            hold_left = 0;
	int            quiet_cycles = 0;
	bit            hold_done = 1'b0;
	bit            calm = 1'b0;

	lease_row_t script [SCRIPT_ROWS] = '{
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_RELEASE, 48'h0, 1'b1, ST_UNKNOWN, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h0, 1'b1, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'hFFFF_FFFF_FFFF, 1'b1, ST_NEW, 32'h1},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h0, 1'b1, ST_EXISTING, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_RELEASE, 48'h0, 1'b1, ST_RELEASED, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h5555_5555_5555, 1'b1, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_BASE_IP, 32'hFFFF_FFFF, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'hFFFF_FFFF_FFFF, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'hAAAA_AAAA_AAAA, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_BASE_IP, 32'hC0A8_0100, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_SIZE, 32'd2, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h1234_5678_9ABC, 1'b1, ST_EXHAUSTED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_RELEASE, 48'hAAAA_AAAA_AAAA, 1'b1, ST_RELEASED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h1234_5678_9ABC, 1'b1, ST_EXHAUSTED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_RELEASE, 48'hFFFF_FFFF_FFFF, 1'b1, ST_RELEASED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h1234_5678_9ABC, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_SIZE, 32'd0, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h0F0F_0F0F_0F0F, 1'b1, ST_EXHAUSTED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h5555_5555_5555, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_SIZE, 32'd511, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h0F0F_0F0F_0F0F, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_SIZE, 32'd1, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'hF0F0_F0F0_F0F0, 1'b1, ST_EXHAUSTED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_RELEASE, 48'h5555_5555_5555, 1'b1, ST_RELEASED,
			32'h0},
		'{WORD_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'hF0F0_F0F0_F0F0, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_SIZE, 32'd256, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0},
		'{REG_ROW, REG_POOL_BASE_IP, 32'h0, CMD_REQUEST, 48'h0, 1'b0, ST_NEW, 32'h0}
	};

	// fill to a full table, shrink under held leases, tiny and empty pools, wrap, drain
	phase_t phases [PHASES] = '{
		'{32'h0, 1'b1, 9'd256, 1'b0, 100, 10, 20},
		'{32'h0A00_0000, 1'b0, 9'd40, 1'b0, 80, 50, 60},
		'{32'h0, 1'b1, 9'd1, 1'b0, 60, 45, 50},
		'{32'hFFFF_FFFF, 1'b0, 9'd0, 1'b0, 30, 30, 50},
		'{32'hFFFF_FFF0, 1'b0, 9'd511, 1'b0, 100, 35, 40},
		'{32'h0, 1'b1, 9'd0, 1'b1, 100, 40, 50},
		'{32'h0, 1'b0, 9'd256, 1'b0, 80, 75, 80},
		'{32'h0, 1'b1, 9'd8, 1'b0, 90, 45, 50}
	};

	address_lease_pool_core #(
		.MAX_CLIENTS (CLIENT_SLOTS),
		.POOL_DEPTH  (POOL_SLOTS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic lease_answer_t lease_outcome(input logic cmd, input logic [MAC_W-1:0] mac);
		lease_answer_t r;
		int i;
		int hit;
		int lim;
		int off;
		r.status = ST_UNKNOWN;
		r.ip = 32'h0;
		hit = held_count;
		for (i = 0; i < held_count && hit == held_count; i++)
			if (held_mac[i] == mac)
				hit = i;
		if (cmd == CMD_REQUEST) begin
			if (hit < held_count) begin
				r.status = ST_EXISTING;
				r.ip = base_ip + held_off[hit];
			end else if (held_count >= CLIENT_SLOTS) begin
				r.status = ST_TABLE_FULL;
			end else begin
				lim = (size_reg > POOL_SLOTS) ? POOL_SLOTS : int'(size_reg);
				r.status = ST_EXHAUSTED;
				off = lim;
				for (i = 0; i < lim && off == lim; i++)
					if (!slot_busy[i])
						off = i;
				if (off < lim) begin
					slot_busy[off] = 1'b1;
					held_mac[held_count] = mac;
					held_off[held_count] = off[7:0];
					held_count++;
					r.status = ST_NEW;
					r.ip = base_ip + off[31:0];
				end
			end
		end else if (hit < held_count) begin
			slot_busy[held_off[hit]] = 1'b0;
			for (i = hit; i + 1 < held_count; i++) begin
				held_mac[i] = held_mac[i + 1];
				held_off[i] = held_off[i + 1];
			end
			held_count--;
			r.status = ST_RELEASED;
		end
		return r;
	endfunction

	task automatic pause_sender();
		if (!calm && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// s_tvalid stays high on return so back-to-back words need no second assignment
	task automatic offer_word(input logic cmd, input logic [MAC_W-1:0] mac, input bit typed,
			input status_t st, input logic [31:0] ip);
		lease_answer_t model;
		lease_answer_t typed_ans;
		s_tvalid <= 1'b1;
		s_tdata  <= mac;
		s_tuser  <= cmd;
		do @(posedge clk); while (s_tready !== 1'b1);
		model = lease_outcome(cmd, mac);
		typed_ans.status = st;
		typed_ans.ip = ip;
		lease_answers_q.push_back(typed ? typed_ans : model);
	endtask

	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (lease_answers_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_BASE_IP)
			base_ip = value;
		else
			size_reg = value[8:0];
	endtask

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (lease_answers_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
				n_fail++;
			end else begin
				due = lease_answers_q.pop_front();
				if (m_tdata[2:0] !== due.status) begin
					$display("%0t: status expected %0d got %0d", $time, due.status, m_tdata[2:0]);
					n_fail++;
				end
				if (m_tdata[34:3] !== due.ip) begin
					$display("%0t: lease ip expected %h got %h", $time, due.ip, m_tdata[34:3]);
					n_fail++;
				end
			end
			words_out++;
		end
		if (!hold_done && words_out == HOLD_AT_WORD) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 12) begin
			stall_left = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int k;
		int p;
		int n;
		logic cmd;
		logic [MAC_W-1:0] mac;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_POOL_BASE_IP;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_REQUEST;
		m_tready  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < SCRIPT_ROWS; k++) begin
			if (script[k].kind == REG_ROW) begin
				write_reg(script[k].idx, script[k].value);
			end else begin
				pause_sender();
				offer_word(script[k].cmd, script[k].mac, script[k].typed, script[k].status,
					script[k].ip);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			write_reg(REG_POOL_BASE_IP, phases[p].base_rand ? $urandom : phases[p].base);
			write_reg(REG_POOL_SIZE,
				phases[p].size_rand ? $urandom_range(1, 300) : {23'h0, phases[p].size});
			calm = (p == PHASES - 1);
			for (n = 0; n < phases[p].items; n++) begin
				pause_sender();
				cmd = ($urandom_range(0, 99) < phases[p].rel_pct) ? CMD_RELEASE : CMD_REQUEST;
				if (held_count > 0 &&
						$urandom_range(0, 99) < (cmd == CMD_RELEASE ? 80 : phases[p].known_pct)) begin
					mac = held_mac[$urandom_range(0, held_count - 1)];
				end else begin
					mac[47:32] = 16'($urandom);
					mac[31:0]  = $urandom;
				end
				offer_word(cmd, mac, 1'b0, ST_UNKNOWN, 32'h0);
			end
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0 && lease_answers_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/alp_pkg.sv
sv/alp_bitmap.sv
sv/address_lease_pool_core.sv
bench/address_lease_pool_core_tb.sv
